// ===== hw/rtl/poi_pkg.sv =====
// Package with payload types, sequencer states and the CORDIC angle table.
package poi_pkg;

    typedef struct packed {
        logic signed [23:0] forward_velocity;
        logic signed [23:0] lateral_velocity;
        logic signed [23:0] yaw_rate;
        logic        [19:0] elapsed_time;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] position_x;
        logic signed [31:0] position_y;
        logic        [31:0] heading_angle;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COR1,
        ST_MUL_XA,
        ST_MUL_XB,
        ST_MUL_XC,
        ST_MUL_XD,
        ST_MUL_YA,
        ST_MUL_YB,
        ST_MUL_YC,
        ST_MUL_YD,
        ST_MUL_HA,
        ST_MUL_HB,
        ST_MUL_HC,
        ST_COR2,
        ST_OUT
    } t_state;

    localparam int TABLE_LEN = 30;
    localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
    localparam logic [31:0] INV_TWO_PI_Q32 = 32'd683565276;

    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0: v = 32'd536870912;  5'd1: v = 32'd316933406;
            5'd2: v = 32'd167458907;  5'd3: v = 32'd85004756;
            5'd4: v = 32'd42667331;   5'd5: v = 32'd21354465;
            5'd6: v = 32'd10679838;   5'd7: v = 32'd5340245;
            5'd8: v = 32'd2670163;    5'd9: v = 32'd1335087;
            5'd10: v = 32'd667544;    5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;    5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;     5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;     5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;      5'd19: v = 32'd1304;
            5'd20: v = 32'd652;       5'd21: v = 32'd326;
            5'd22: v = 32'd163;       5'd23: v = 32'd81;
            5'd24: v = 32'd41;        5'd25: v = 32'd20;
            5'd26: v = 32'd10;        5'd27: v = 32'd5;
            5'd28: v = 32'd3;         5'd29: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/poi_cordic.sv =====
// Iterative rotation-mode CORDIC: one micro-rotation per cycle, Q2.30 results.
module poi_cordic #(
    parameter int ITERATIONS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic        [31:0] i_angle,
    output logic               o_done,
    output logic signed [33:0] o_cos,
    output logic signed [33:0] o_sin
);
    import poi_pkg::*;

    localparam int NITER = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;

    logic signed [33:0] r_x, r_y;
    logic signed [32:0] r_z;
    logic               r_flip, r_busy, r_done;
    logic        [4:0]  r_i;
    logic        [31:0] ang;
    logic signed [33:0] dx, dy;
    logic signed [32:0] at;

    assign ang = (i_angle[31:30] == 2'd1 || i_angle[31:30] == 2'd2)
                 ? i_angle + 32'h8000_0000 : i_angle;
    assign dx  = r_x >>> r_i;
    assign dy  = r_y >>> r_i;
    assign at  = $signed({1'b0, atan_turn(r_i)});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_i    <= '0;
                r_x    <= CORDIC_START;
                r_y    <= '0;
                r_z    <= {ang[31], ang};
                r_flip <= (i_angle[31:30] == 2'd1 || i_angle[31:30] == 2'd2);
            end else if (r_busy) begin
                if (r_z >= 0) begin
                    r_x <= r_x - dy;
                    r_y <= r_y + dx;
                    r_z <= r_z - at;
                end else begin
                    r_x <= r_x + dy;
                    r_y <= r_y - dx;
                    r_z <= r_z + at;
                end
                r_i <= r_i + 5'd1;
                if (r_i == 5'(NITER - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_cos  = r_flip ? -r_x : r_x;
    assign o_sin  = r_flip ? -r_y : r_y;
endmodule

// ===== hw/rtl/poi_mac.sv =====
// Shared signed multiplier with a registered product, used once per step.
module poi_mac (
    input  logic               i_clk,
    input  logic signed [33:0] i_a,
    input  logic signed [33:0] i_b,
    output logic signed [67:0] o_p
);
    import poi_pkg::*;

    logic signed [67:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;
endmodule

// ===== hw/rtl/planar_odometry_integrator.sv =====
// Top level of the planar odometry integrator: sequencer, accumulators, output register.
// Planar odometry integrator.
// The input channel (i_in_valid / o_in_ready, payload i_in_item) takes one
// odometry tick: body velocities, yaw rate and elapsed time. The output
// channel (o_out_valid / i_out_ready, payload o_out_item) returns the new
// pose and the yaw quaternion of the new heading, one item per tick.
// The block takes a new item only once the previous result has been
// accepted. The pace is set by the shared CORDIC, which runs twice per
// item (old heading, then half of the new heading) at one micro-rotation
// per cycle, and by the one shared multiplier that forms the nine
// products in turn.
// Reset clears the position and heading accumulators to zero and empties
// the output register. When the receiver stalls, the result is held stable
// in the output register and the input stays not ready.
// Note that the multiplier operands are kept at 34 bits; the wide
// velocity-times-cosine sums are formed from two products and one add or subtract.
module planar_odometry_integrator #(
    parameter int ANGLE_ITERATIONS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  poi_pkg::t_in_item   i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output poi_pkg::t_out_item  o_out_item
);
    import poi_pkg::*;

    t_state r_state, n_state;

    logic signed [31:0] r_px, r_py;
    logic        [31:0] r_h;
    t_in_item           r_in;
    logic signed [33:0] r_c, r_s;
    logic signed [67:0] r_acc;
    logic signed [33:0] r_t24;
    logic        [63:0] r_hacc;
    logic signed [44:0] r_hp;
    t_out_item          r_out;
    logic               r_out_valid;

    logic               cor_start, cor_done;
    logic        [31:0] cor_angle;
    logic signed [33:0] cor_c, cor_s;
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] mul_p;

    logic [31:0] n_h;
    logic [63:0] hsum;
    logic [31:0] hdel;

    // Heading product magnitude; yaw rate times dt comes from the shared multiplier.
    logic        [44:0] hmag;
    assign hmag = r_hp[44] ? 45'(-r_hp) : 45'(r_hp);

    poi_cordic #(.ITERATIONS(ANGLE_ITERATIONS)) u_cordic (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(cor_start),
        .i_angle(cor_angle),
        .o_done (cor_done),
        .o_cos  (cor_c),
        .o_sin  (cor_s)
    );

    poi_mac u_mac (
        .i_clk(i_clk),
        .i_a  (mul_a),
        .i_b  (mul_b),
        .o_p  (mul_p)
    );

    // Operand selection for the shared multiplier, at most one product per state.
    // The product appears one state later.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            ST_MUL_XA: begin mul_a = 34'(r_in.forward_velocity); mul_b = r_c; end
            ST_MUL_XB: begin mul_a = 34'(r_in.lateral_velocity); mul_b = r_s; end
            ST_MUL_XC: begin
                mul_a = 34'(r_in.yaw_rate); mul_b = $signed({14'd0, r_in.elapsed_time});
            end
            ST_MUL_XD, ST_MUL_YD: begin
                mul_a = r_t24; mul_b = $signed({14'd0, r_in.elapsed_time});
            end
            ST_MUL_YA: begin mul_a = 34'(r_in.forward_velocity); mul_b = r_s; end
            ST_MUL_YB: begin mul_a = 34'(r_in.lateral_velocity); mul_b = r_c; end
            ST_MUL_HA: begin
                mul_a = $signed({11'd0, hmag[44:22]});
                mul_b = $signed({2'd0, INV_TWO_PI_Q32});
            end
            ST_MUL_HB: begin
                mul_a = $signed({12'd0, hmag[21:0]});
                mul_b = $signed({2'd0, INV_TWO_PI_Q32});
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state   = r_state;
        cor_start = 1'b0;
        cor_angle = r_h;
        case (r_state)
            ST_IDLE: if (i_in_valid && !r_out_valid) begin
                n_state   = ST_COR1;
            end
            ST_COR1:   if (cor_done) n_state = ST_MUL_XA;
            ST_MUL_XA: n_state = ST_MUL_XB;
            ST_MUL_XB: n_state = ST_MUL_XC;
            ST_MUL_XC: n_state = ST_MUL_XD;
            ST_MUL_XD: n_state = ST_MUL_YA;
            ST_MUL_YA: n_state = ST_MUL_YB;
            ST_MUL_YB: n_state = ST_MUL_YC;
            ST_MUL_YC: n_state = ST_MUL_YD;
            ST_MUL_YD: n_state = ST_MUL_HA;
            ST_MUL_HA: n_state = ST_MUL_HB;
            ST_MUL_HB: n_state = ST_MUL_HC;
            ST_MUL_HC: n_state = ST_COR2;
            ST_COR2:   if (cor_done) n_state = ST_OUT;
            ST_OUT:    n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
        if (r_state == ST_IDLE && n_state == ST_COR1) cor_start = 1'b1;
        if (r_state == ST_MUL_HC) begin
            cor_start = 1'b1;
            cor_angle = {1'b0, n_h[31:1]};
        end
    end

    // Saturating position add.
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [67:0] p);
        logic signed [44:0] d;
        logic signed [45:0] s;
        d = 45'((p + 68'sd8388608) >>> 24);
        s = 46'(a) + 46'(d);
        if (s > 46'sd2147483647) return 32'h7FFF_FFFF;
        if (s < -46'sd2147483648) return 32'h8000_0000;
        return s[31:0];
    endfunction

    function automatic logic signed [15:0] to_q15(input logic signed [33:0] v);
        logic signed [34:0] r;
        r = (35'(v) + 35'sd16384) >>> 15;
        if (r > 35'sd32767) return 16'sh7FFF;
        if (r < -35'sd32768) return 16'sh8000;
        return r[15:0];
    endfunction

    assign hsum = r_hacc + 64'((mul_p[63:0] + 64'h8000_0000) >> 22);
    assign hdel = r_hp[44] ? 32'(0 - hsum[41:10]) : hsum[41:10];
    assign n_h  = r_h + hdel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_px        <= '0;
            r_py        <= '0;
            r_h         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            case (r_state)
                ST_IDLE: if (n_state == ST_COR1) r_in <= i_in_item;
                ST_COR1: if (cor_done) begin r_c <= cor_c; r_s <= cor_s; end
                ST_MUL_XB, ST_MUL_YB: r_acc <= mul_p;
                ST_MUL_XC: r_t24 <= 34'((r_acc - mul_p + 68'sd2097152) >>> 22);
                ST_MUL_XD: r_hp <= mul_p[44:0];
                ST_MUL_YA: r_px <= sat_add(r_px, mul_p);
                ST_MUL_YC: r_t24 <= 34'((r_acc + mul_p + 68'sd2097152) >>> 22);
                ST_MUL_HA: r_py <= sat_add(r_py, mul_p);
                ST_MUL_HB: r_hacc <= mul_p[63:0];
                ST_MUL_HC: r_h <= n_h;
                ST_COR2: if (cor_done) begin
                    r_out.position_x    <= r_px;
                    r_out.position_y    <= r_py;
                    r_out.heading_angle <= r_h;
                    r_out.quat_z        <= to_q15(cor_s);
                    r_out.quat_w        <= to_q15(cor_c);
                    r_out_valid         <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE) && !r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    // No input is taken while a result waits.
    a_no_take_while_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !o_in_ready) else $error("input ready while result pending");
    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> (r_out_valid && $stable(r_out)))
        else $error("stalled result changed");
    // Heading only changes at its update state.
    a_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_MUL_HC) |=> $stable(r_h)) else $error("heading changed early");
endmodule
